@@ hw/rtl/ufic_pkg.sv @@
package ufic_pkg;

  // Frame offset counter width; covers minimum frame lengths up to 127.
  localparam int unsigned OFF_W = 7;

  typedef logic [OFF_W-1:0] off_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_UDP_PORT     = 2'd0,
    REG_CLUSTER_ID   = 2'd1,
    REG_SCHEMA_ID    = 2'd2,
    REG_BOUND_QUEUES = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] UDP_PORT_RST   = 16'd47911;
  localparam logic [31:0] CLUSTER_ID_RST = 32'd1;
  localparam logic [31:0] SCHEMA_ID_RST  = 32'd0;

  // Checked header offsets
  localparam off_t OFF_ETYPE_HI = 7'd12;
  localparam off_t OFF_ETYPE_LO = 7'd13;
  localparam off_t OFF_IP_VIHL  = 7'd14;
  localparam off_t OFF_IP_FRAG0 = 7'd20;
  localparam off_t OFF_IP_FRAG1 = 7'd21;
  localparam off_t OFF_IP_PROTO = 7'd23;
  localparam off_t OFF_DPORT_HI = 7'd36;
  localparam off_t OFF_DPORT_LO = 7'd37;
  localparam off_t OFF_MAGIC0   = 7'd42;
  localparam off_t OFF_MAGIC1   = 7'd43;
  localparam off_t OFF_MAGIC2   = 7'd44;
  localparam off_t OFF_MAGIC3   = 7'd45;
  localparam off_t OFF_VER_LO   = 7'd46;
  localparam off_t OFF_VER_HI   = 7'd47;
  localparam off_t OFF_CLUS0    = 7'd50;
  localparam off_t OFF_CLUS1    = 7'd51;
  localparam off_t OFF_CLUS2    = 7'd52;
  localparam off_t OFF_CLUS3    = 7'd53;
  localparam off_t OFF_SCHEMA0  = 7'd54;
  localparam off_t OFF_SCHEMA1  = 7'd55;
  localparam off_t OFF_SCHEMA2  = 7'd56;
  localparam off_t OFF_SCHEMA3  = 7'd57;

  // Expected header byte values
  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [3:0] IHL_NO_OPTS   = 4'd5;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] MAGIC_B0      = 8'h2E;  // '.'
  localparam logic [7:0] MAGIC_B1      = 8'h77;  // 'w'
  localparam logic [7:0] MAGIC_B2      = 8'h66;  // 'f'
  localparam logic [7:0] MAGIC_B3      = 8'h74;  // 't'
  localparam logic [7:0] VERSION_LO    = 8'd1;
  localparam logic [7:0] VERSION_HI    = 8'd0;

  // Match keys handed from the register block to the byte checker
  typedef struct packed {
    logic [15:0] udp_port;
    logic [31:0] cluster_id;
    logic [31:0] schema_id;
  } match_keys_t;

endpackage

@@ hw/rtl/ufic_cfg_regs.sv @@
module ufic_cfg_regs
  import ufic_pkg::*;
#(
  parameter int unsigned NUM_QUEUES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_wdata,
  output match_keys_t           keys,
  output logic [NUM_QUEUES-1:0] bound_queues
);

  logic [15:0]           udp_port_r;
  logic [31:0]           cluster_id_r;
  logic [31:0]           schema_id_r;
  logic [NUM_QUEUES-1:0] bound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      udp_port_r   <= UDP_PORT_RST;
      cluster_id_r <= CLUSTER_ID_RST;
      schema_id_r  <= SCHEMA_ID_RST;
      bound_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UDP_PORT:     udp_port_r   <= cfg_wdata[15:0];
        REG_CLUSTER_ID:   cluster_id_r <= cfg_wdata[31:0];
        REG_SCHEMA_ID:    schema_id_r  <= cfg_wdata[31:0];
        REG_BOUND_QUEUES: bound_r      <= cfg_wdata[NUM_QUEUES-1:0];
        default: ;
      endcase
    end
  end

  assign keys.udp_port   = udp_port_r;
  assign keys.cluster_id = cluster_id_r;
  assign keys.schema_id  = schema_id_r;
  assign bound_queues    = bound_r;

endmodule

@@ hw/rtl/ufic_byte_check.sv @@
module ufic_byte_check
  import ufic_pkg::*;
(
  input  off_t        offset,
  input  logic [7:0]  frame_byte,
  input  match_keys_t keys,
  output logic        byte_ok
);

  logic any_schema;

  assign any_schema = (keys.schema_id == 32'd0);

  always_comb begin
    unique case (offset)
      OFF_ETYPE_HI: byte_ok = (frame_byte == ETYPE_IPV4_HI);
      OFF_ETYPE_LO: byte_ok = (frame_byte == ETYPE_IPV4_LO);
      OFF_IP_VIHL:  byte_ok = (frame_byte[3:0] == IHL_NO_OPTS);
      OFF_IP_FRAG0: byte_ok = (frame_byte[5:0] == 6'd0);   // MF and offset high bits
      OFF_IP_FRAG1: byte_ok = (frame_byte == 8'd0);
      OFF_IP_PROTO: byte_ok = (frame_byte == PROTO_UDP);
      OFF_DPORT_HI: byte_ok = (frame_byte == keys.udp_port[15:8]);
      OFF_DPORT_LO: byte_ok = (frame_byte == keys.udp_port[7:0]);
      OFF_MAGIC0:   byte_ok = (frame_byte == MAGIC_B0);
      OFF_MAGIC1:   byte_ok = (frame_byte == MAGIC_B1);
      OFF_MAGIC2:   byte_ok = (frame_byte == MAGIC_B2);
      OFF_MAGIC3:   byte_ok = (frame_byte == MAGIC_B3);
      OFF_VER_LO:   byte_ok = (frame_byte == VERSION_LO);
      OFF_VER_HI:   byte_ok = (frame_byte == VERSION_HI);
      OFF_CLUS0:    byte_ok = (frame_byte == keys.cluster_id[7:0]);
      OFF_CLUS1:    byte_ok = (frame_byte == keys.cluster_id[15:8]);
      OFF_CLUS2:    byte_ok = (frame_byte == keys.cluster_id[23:16]);
      OFF_CLUS3:    byte_ok = (frame_byte == keys.cluster_id[31:24]);
      OFF_SCHEMA0:  byte_ok = any_schema || (frame_byte == keys.schema_id[7:0]);
      OFF_SCHEMA1:  byte_ok = any_schema || (frame_byte == keys.schema_id[15:8]);
      OFF_SCHEMA2:  byte_ok = any_schema || (frame_byte == keys.schema_id[23:16]);
      OFF_SCHEMA3:  byte_ok = any_schema || (frame_byte == keys.schema_id[31:24]);
      default:      byte_ok = 1'b1;
    endcase
  end

endmodule

@@ hw/rtl/udp_frame_ingress_classifier_core.sv @@
// Channel   Direction  Ports                                       Handshake
// input     in         in_frame_byte, in_last_byte, in_rx_queue    in_valid / in_stall
// result    out        out_verdict, out_target_queue               out_valid / out_stall
// config    in         cfg_index, cfg_wdata                        cfg_we (no wait)
//
// One byte item per cycle, sustained while in_stall is low. Each item is held in the
// input register, where the header check and verdict logic run; a last-byte item
// loads the result register, which drives out_valid, when it advances.
// Reset (rst_n low, synchronous) restores the register defaults and arms a new frame.
// in_stall rises only when a last-byte item waits while the result register
// is still held by out_stall; other bytes move through regardless.
module udp_frame_ingress_classifier_core
  import ufic_pkg::*;
#(
  parameter int unsigned MIN_FRAME_BYTES = 106,
  parameter int unsigned NUM_QUEUES      = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  input  logic [5:0]  in_rx_queue,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_verdict,
  output logic [5:0]  out_target_queue,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam off_t MIN_OFF = OFF_W'(MIN_FRAME_BYTES);

  // Register block
  match_keys_t           keys;
  logic [NUM_QUEUES-1:0] bound_queues;

  ufic_cfg_regs #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_cfg_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .keys         (keys),
    .bound_queues (bound_queues)
  );

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic [5:0] in_queue_r;

  // Frame tracking state
  off_t offset_r, offset_nxt;
  logic match_r,  match_nxt;

  // Result register
  logic       out_vld_r;
  logic       verdict_r, verdict_nxt;
  logic [5:0] queue_r;

  logic out_free;
  logic advance;
  logic in_accept;
  logic byte_ok;
  logic saturated;
  logic long_enough;
  logic bound;
  logic [63:0] bound_ext;

  // Non-last bytes never need the result slot, so they always move on.
  assign out_free  = !out_vld_r || !out_stall;
  assign advance   = in_vld_r && (!in_last_r || out_free);
  assign in_stall  = in_vld_r && in_last_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_accept) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r  <= in_frame_byte;
      in_last_r  <= in_last_byte;
      in_queue_r <= in_rx_queue;
    end
  end

  ufic_byte_check u_byte_check (
    .offset     (offset_r),
    .frame_byte (in_byte_r),
    .keys       (keys),
    .byte_ok    (byte_ok)
  );

  // Bytes past the minimum length are not examined; offset holds there.
  assign saturated = (offset_r >= MIN_OFF);

  // Queues at or above NUM_QUEUES read as unbound through the zero extension.
  assign bound_ext = 64'(bound_queues);
  assign bound     = bound_ext[in_queue_r];

  always_comb begin
    offset_nxt  = offset_r;
    match_nxt   = match_r;
    if (!saturated) begin
      offset_nxt = offset_r + 1'b1;
      match_nxt  = match_r && byte_ok;
    end
    long_enough = (offset_nxt >= MIN_OFF);
    verdict_nxt = match_nxt && long_enough && bound;
    // last byte re-arms the frame
    if (in_last_r) begin
      offset_nxt = '0;
      match_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      match_r  <= 1'b1;
    end else if (advance) begin
      offset_r <= offset_nxt;
      match_r  <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      verdict_r <= verdict_nxt;
      queue_r   <= in_queue_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_verdict      = verdict_r;
  assign out_target_queue = queue_r;

endmodule

@@ dv/ufic_verdict_checker.sv @@
`timescale 1ns / 100ps

// Watches the byte and verdict channels plus register writes, predicts one
// verdict per frame and compares it with what the block returns.
module ufic_verdict_checker
  import ufic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  input  logic [5:0]  in_rx_queue,

  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_verdict,
  input  logic [5:0]  out_target_queue,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,

  output int          pending,
  output int          fail_count
);

  localparam int unsigned MIN_FRAME_BYTES = 106;
  localparam int unsigned NUM_QUEUES      = 64;

  typedef struct packed {
    logic       verdict;
    logic [5:0] target_queue;
  } steer_t;

  steer_t      expected_verdicts[$];

  // register shadow
  logic [15:0] port_key;
  logic [31:0] cluster_key;
  logic [31:0] schema_key;
  logic [63:0] bound_mask;

  // per-frame parse state
  off_t        frame_off;
  logic        hdr_ok;
  int          mismatches = 0;

  function automatic logic [7:0] key_lane(logic [31:0] key, int lane);
    return key[8*lane +: 8];
  endfunction

  // Does byte b at header offset off keep the frame eligible for redirect?
  function automatic logic hdr_byte_ok(off_t off, logic [7:0] b);
    case (off)
      OFF_ETYPE_HI: return b == ETYPE_IPV4_HI;
      OFF_ETYPE_LO: return b == ETYPE_IPV4_LO;
      OFF_IP_VIHL:  return b[3:0] == IHL_NO_OPTS;
      OFF_IP_FRAG0: return b[5:0] == 6'd0;  // MF and offset high bits
      OFF_IP_FRAG1: return b == 8'd0;
      OFF_IP_PROTO: return b == PROTO_UDP;
      OFF_DPORT_HI: return b == port_key[15:8];
      OFF_DPORT_LO: return b == port_key[7:0];
      OFF_MAGIC0:   return b == MAGIC_B0;
      OFF_MAGIC1:   return b == MAGIC_B1;
      OFF_MAGIC2:   return b == MAGIC_B2;
      OFF_MAGIC3:   return b == MAGIC_B3;
      OFF_VER_LO:   return b == VERSION_LO;
      OFF_VER_HI:   return b == VERSION_HI;
      OFF_CLUS0, OFF_CLUS1, OFF_CLUS2, OFF_CLUS3:
        return b == key_lane(cluster_key, int'(off - OFF_CLUS0));
      OFF_SCHEMA0, OFF_SCHEMA1, OFF_SCHEMA2, OFF_SCHEMA3:
        return schema_key == '0 || b == key_lane(schema_key, int'(off - OFF_SCHEMA0));
      default:      return 1'b1;
    endcase
  endfunction

  always @(posedge clk) begin : verdict_scoreboard
    steer_t want;
    logic   redirect;
    if (!rst_n) begin
      port_key    = UDP_PORT_RST;
      cluster_key = CLUSTER_ID_RST;
      schema_key  = SCHEMA_ID_RST;
      bound_mask  = '0;
      frame_off   = '0;
      hdr_ok      = 1'b1;
      expected_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("verdict item with none expected: verdict %0d target_queue %0d",
                 out_verdict, out_target_queue);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, out_verdict);
            mismatches++;
          end
          if (out_target_queue !== want.target_queue) begin
            $error("target_queue: expected %0d, got %0d",
                   want.target_queue, out_target_queue);
            mismatches++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        // offset saturates, bytes past the minimum length are not looked at
        if (frame_off < MIN_FRAME_BYTES) begin
          if (!hdr_byte_ok(frame_off, in_frame_byte))
            hdr_ok = 1'b0;
          frame_off++;
        end
        if (in_last_byte) begin
          redirect = hdr_ok && frame_off >= MIN_FRAME_BYTES &&
                     in_rx_queue < NUM_QUEUES && bound_mask[in_rx_queue];
          expected_verdicts.push_back('{redirect, in_rx_queue});
          frame_off = '0;
          hdr_ok    = 1'b1;
        end
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_UDP_PORT:     port_key    = cfg_wdata[15:0];
          REG_CLUSTER_ID:   cluster_key = cfg_wdata[31:0];
          REG_SCHEMA_ID:    schema_key  = cfg_wdata[31:0];
          REG_BOUND_QUEUES: bound_mask  = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending    <= expected_verdicts.size();
    fail_count <= mismatches;
  end

endmodule

@@ dv/udp_frame_ingress_classifier_core_test.sv @@
`timescale 1ns / 100ps

module udp_frame_ingress_classifier_core_test
  import ufic_pkg::*;
;

  localparam int unsigned MIN_FRAME_BYTES = 106;
  localparam int          RANDOM_BYTES    = 560;
  localparam int          RANDOM_FRAMES   = 30;
  localparam int          PHASE_BYTES     = 110;
  localparam int          SETTLE_CYCLES   = 6;      // input and result registers plus margin
  localparam int          LONG_HOLD       = 300;    // receiver hold-off for backpressure
  localparam int          CYCLE_LIMIT     = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_frame_byte;
  logic        in_last_byte;
  logic [5:0]  in_rx_queue;
  logic        out_valid;
  logic        out_stall;
  logic        out_verdict;
  logic [5:0]  out_target_queue;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  int          pending;
  int          fail_count;

  // Stimulus-side copy of the registers: only used to build headers that
  // match (or nearly match) the current keys.
  logic [15:0] port_cfg;
  logic [31:0] cluster_cfg;
  logic [31:0] schema_cfg;
  logic [63:0] bound_cfg;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  bit          hold_active    = 1'b0;
  int          bytes_sent     = 0;
  int          frames_sent    = 0;
  int          cycle_count    = 0;

  // Every offset the block checks; used to aim header corruption.
  off_t hdr_offs [0:21] = '{
    OFF_ETYPE_HI, OFF_ETYPE_LO, OFF_IP_VIHL, OFF_IP_FRAG0, OFF_IP_FRAG1,
    OFF_IP_PROTO, OFF_DPORT_HI, OFF_DPORT_LO, OFF_MAGIC0, OFF_MAGIC1,
    OFF_MAGIC2, OFF_MAGIC3, OFF_VER_LO, OFF_VER_HI, OFF_CLUS0, OFF_CLUS1,
    OFF_CLUS2, OFF_CLUS3, OFF_SCHEMA0, OFF_SCHEMA1, OFF_SCHEMA2, OFF_SCHEMA3
  };

  udp_frame_ingress_classifier_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_byte    (in_frame_byte),
    .in_last_byte     (in_last_byte),
    .in_rx_queue      (in_rx_queue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_target_queue (out_target_queue),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  ufic_verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_byte    (in_frame_byte),
    .in_last_byte     (in_last_byte),
    .in_rx_queue      (in_rx_queue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_target_queue (out_target_queue),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .pending          (pending),
    .fail_count       (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop if the run hangs (lost verdict, stuck stall, ...).
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // Receiver: random stall bursts, plus one long counted hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
      end else if ($urandom_range(99) < recv_stall_pct) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Header byte that passes the check at offset o under the current keys.
  // Bits the block ignores are randomized.
  function automatic logic [7:0] good_byte(off_t o);
    case (o)
      OFF_ETYPE_HI: return ETYPE_IPV4_HI;
      OFF_ETYPE_LO: return ETYPE_IPV4_LO;
      OFF_IP_VIHL:  return {4'($urandom), IHL_NO_OPTS};
      OFF_IP_FRAG0: return {2'($urandom), 6'd0};
      OFF_IP_FRAG1: return 8'd0;
      OFF_IP_PROTO: return PROTO_UDP;
      OFF_DPORT_HI: return port_cfg[15:8];
      OFF_DPORT_LO: return port_cfg[7:0];
      OFF_MAGIC0:   return MAGIC_B0;
      OFF_MAGIC1:   return MAGIC_B1;
      OFF_MAGIC2:   return MAGIC_B2;
      OFF_MAGIC3:   return MAGIC_B3;
      OFF_VER_LO:   return VERSION_LO;
      OFF_VER_HI:   return VERSION_HI;
      OFF_CLUS0, OFF_CLUS1, OFF_CLUS2, OFF_CLUS3:
        return cluster_cfg[8*int'(o - OFF_CLUS0) +: 8];
      OFF_SCHEMA0, OFF_SCHEMA1, OFF_SCHEMA2, OFF_SCHEMA3:
        return (schema_cfg == '0) ? 8'($urandom) : schema_cfg[8*int'(o - OFF_SCHEMA0) +: 8];
      default:      return 8'($urandom);
    endcase
  endfunction

  // Nonzero flip limited to the bits that are actually checked.
  function automatic logic [7:0] bad_mask(off_t o);
    case (o)
      OFF_IP_VIHL:  return {4'd0, 4'($urandom_range(1, 15))};
      OFF_IP_FRAG0: return {2'd0, 6'($urandom_range(1, 63))};
      default:      return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Mostly a queue with a bound socket, when there is one.
  function automatic logic [5:0] pick_queue();
    logic [5:0] q;
    q = 6'($urandom);
    if (bound_cfg != '0 && $urandom_range(99) < 80)
      for (int n = 0; n < 200 && !bound_cfg[q]; n++)
        q = 6'($urandom);
    return q;
  endfunction

  // One byte item; holds its payload until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [5:0] q);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_frame_byte <= b;
    in_last_byte  <= last;
    in_rx_queue   <= q;
    do @(posedge clk); while (in_stall);
  endtask

  // Bytes first..stop-1 of a frame of len bytes. With good_hdr the checked
  // offsets carry matching values, except bad_off which gets corrupted.
  // rx_queue is random on every byte but the last.
  task automatic send_part(input int first, input int stop, input int len,
                           input bit good_hdr, input int bad_off,
                           input logic [5:0] q);
    logic [7:0] b;
    logic       last;
    for (int o = first; o < stop; o++) begin
      if (good_hdr && o < MIN_FRAME_BYTES) begin
        b = good_byte(off_t'(o));
        if (o == bad_off)
          b = b ^ bad_mask(off_t'(o));
      end else begin
        b = 8'($urandom);
      end
      last = (o == len - 1);
      send_byte(b, last, last ? q : 6'($urandom));
      bytes_sent++;
      if (last)
        frames_sent++;
    end
  endtask

  // Drop valid, wait for every verdict, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high so back-to-back writes need no toggle; callers lower it.
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_UDP_PORT:     port_cfg    = v[15:0];
      REG_CLUSTER_ID:   cluster_cfg = v[31:0];
      REG_SCHEMA_ID:    schema_cfg  = v[31:0];
      REG_BOUND_QUEUES: bound_cfg   = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Upper write-data bits above a register's width are junk on purpose.
  task automatic set_config(input logic [15:0] port, input logic [31:0] clus,
                            input logic [31:0] schema, input logic [63:0] bound);
    write_reg(REG_UDP_PORT,     {48'({$urandom, $urandom}), port});
    write_reg(REG_CLUSTER_ID,   {32'($urandom), clus});
    write_reg(REG_SCHEMA_ID,    {32'($urandom), schema});
    write_reg(REG_BOUND_QUEUES, bound);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [15:0] port;
    logic [31:0] clus;
    logic [31:0] schema;
    logic [63:0] bound;
    case ($urandom_range(3))
      0:       port = '0;
      1:       port = '1;
      default: port = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0:       clus = '0;
      1:       clus = '1;
      default: clus = $urandom;
    endcase
    case ($urandom_range(4))
      0, 1:    schema = '0;   // any schema
      2:       schema = '1;
      default: schema = $urandom;
    endcase
    case ($urandom_range(4))
      0:       bound = '0;
      1:       bound = '1;
      2:       bound = 64'(1) << $urandom_range(63);
      default: bound = {$urandom, $urandom};
    endcase
    set_config(port, clus, schema, bound);
  endtask

  // Random frame mix: good headers (some with one bad field), short
  // frames, and plain noise. A few run far past the minimum length.
  task automatic random_frame();
    int kind;
    int len;
    int bad;
    kind = $urandom_range(99);
    bad  = -1;
    if (kind < 45) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(113, 200) : $urandom_range(106, 112);
      if ($urandom_range(99) < 35)
        bad = hdr_offs[$urandom_range(21)];
      send_part(0, len, len, 1'b1, bad, pick_queue());
    end else if (kind < 80) begin
      len = ($urandom_range(9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 105);
      send_part(0, len, len, 1'($urandom_range(1)), -1, pick_queue());
    end else begin
      len = $urandom_range(1, 130);
      send_part(0, len, len, 1'b0, -1, 6'($urandom));
    end
  endtask

  initial begin
    int phase;
    int phase_start;
    int rand_bytes0;
    int rand_frames0;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_frame_byte <= '0;
    in_last_byte  <= 1'b0;
    in_rx_queue   <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_UDP_PORT;
    cfg_wdata     <= '0;
    port_cfg    = UDP_PORT_RST;
    cluster_cfg = CLUSTER_ID_RST;
    schema_cfg  = SCHEMA_ID_RST;
    bound_cfg   = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // Reset keys, no queue bound: everything passes.
    send_part(0, 1, 1, 1'b0, -1, 6'd0);          // single-byte frame
    send_part(0, 106, 106, 1'b1, -1, 6'd5);      // clean header, unbound queue
    settle();

    // All-ones keys, every queue bound, any schema.
    set_config(16'hFFFF, 32'hFFFF_FFFF, 32'h0, '1);
    send_part(0, 106, 106, 1'b1, -1, 6'd63);     // redirect on the top queue
    send_part(0, 105, 105, 1'b1, -1, 6'd0);      // one byte short of the minimum
    send_part(0, 180, 180, 1'b1, -1, 6'd0);      // long frame, tail never examined
    send_part(0, 106, 106, 1'b1, int'(OFF_ETYPE_LO), 6'd7);   // not IPv4
    send_part(0, 106, 106, 1'b1, int'(OFF_IP_FRAG0), 6'd8);   // fragment bits set
    send_part(0, 106, 106, 1'b1, int'(OFF_MAGIC3), 6'd9);     // magic broken
    settle();

    // Zero keys, strict schema, only queue 0 bound.
    set_config(16'h0000, 32'h0, 32'hFFFF_FFFF, 64'h1);
    send_part(0, 106, 106, 1'b1, -1, 6'd0);      // redirect
    send_part(0, 106, 106, 1'b1, -1, 6'd1);      // queue bit clear
    send_part(0, 106, 106, 1'b1, int'(OFF_SCHEMA3), 6'd0);    // schema mismatch

    // Keys change in the middle of a frame: the port was already checked
    // against its old value, the cluster id is checked against the new one.
    send_part(0, 40, 106, 1'b1, -1, 6'd0);
    settle();
    write_reg(REG_UDP_PORT, 64'h1234);
    write_reg(REG_CLUSTER_ID, 64'($urandom));
    cfg_we <= 1'b0;
    send_part(40, 106, 106, 1'b1, -1, 6'd0);

    // ---- random phases, fresh keys and idle profile each ----
    phase        = 0;
    rand_bytes0  = bytes_sent;
    rand_frames0 = frames_sent;
    while (bytes_sent - rand_bytes0 < RANDOM_BYTES ||
           frames_sent - rand_frames0 < RANDOM_FRAMES) begin
      settle();   // sender pauses until every verdict is back
      random_config();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 15; recv_stall_pct = 15; end
        2: begin send_idle_pct = 50; recv_stall_pct = 60; end
        default: begin
          send_idle_pct  = $urandom_range(90);
          recv_stall_pct = $urandom_range(90);
        end
      endcase

      if (phase == 1) begin
        // Backpressure: receiver holds off while short frames keep coming,
        // so the result register fills and in_stall has to rise.
        send_idle_pct = 0;
        hold_req = 1'b1;
        wait (hold_active);
        repeat (30)
          send_part(0, 2, 2, 1'b0, -1, pick_queue());
        send_idle_pct = 15;
      end

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES)
        random_frame();
      phase++;
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ufic_pkg.sv
hw/rtl/ufic_cfg_regs.sv
hw/rtl/ufic_byte_check.sv
hw/rtl/udp_frame_ingress_classifier_core.sv
dv/ufic_verdict_checker.sv
dv/udp_frame_ingress_classifier_core_test.sv
